@@ design/bkt_pkg.sv @@
// ----------------------------------------------------------------------------
// bkt_pkg
// Shared constants and types for the bakery ticket lock arbiter.
// ----------------------------------------------------------------------------
package bkt_pkg;

   localparam int CLIENT_W        = 4;
   localparam int TICKET_OUT_W    = 8;
   localparam int NUM_CLIENTS_DEF = 16;
   localparam int TICKET_BITS_DEF = 8;

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef struct packed {
      logic clear;
      logic beat;
   } bkt_scan_ctl_type;

endpackage

@@ design/bkt_if.sv @@
// ----------------------------------------------------------------------------
// bkt_req_if / bkt_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface bkt_req_if;
   import bkt_pkg::*;

   logic                valid;
   logic                ready;
   logic                op;
   logic [CLIENT_W-1:0] client;

   modport source (output valid, output op, output client, input ready);
   modport sink   (input valid, input op, input client, output ready);
endinterface

interface bkt_rsp_if;
   import bkt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [TICKET_OUT_W-1:0] ticket;
   logic                    overflow;
   logic                    grant_valid;
   logic [CLIENT_W-1:0]     grant_client;

   modport source (output valid, output ticket, output overflow, output grant_valid,
                   output grant_client, input ready);
   modport sink   (input valid, input ticket, input overflow, input grant_valid,
                   input grant_client, output ready);
endinterface

@@ design/bkt_ticket_ram.sv @@
// ----------------------------------------------------------------------------
// bkt_ticket_ram
// Ticket store: one write port, one read port with registered read data.
// Entries not written since reset read as zero.
// ----------------------------------------------------------------------------
module bkt_ticket_ram #(
   parameter int NUM_CLIENTS = bkt_pkg::NUM_CLIENTS_DEF,
   parameter int TICKET_BITS = bkt_pkg::TICKET_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [$clog2(NUM_CLIENTS)-1:0] rd_addr,
   output logic [TICKET_BITS-1:0]         rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(NUM_CLIENTS)-1:0] wr_addr,
   input  logic [TICKET_BITS-1:0]         wr_data
);
   import bkt_pkg::*;

   logic [TICKET_BITS-1:0] mem_ff [NUM_CLIENTS];
   logic [NUM_CLIENTS-1:0] vld_ff;
   logic [TICKET_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bkt_scan_acc.sv @@
// ----------------------------------------------------------------------------
// bkt_scan_acc
// Running maximum over all tickets and running minimum nonzero ticket over
// the other clients, fed one read word per beat in ascending index order.
// ----------------------------------------------------------------------------
module bkt_scan_acc #(
   parameter int NUM_CLIENTS = bkt_pkg::NUM_CLIENTS_DEF,
   parameter int TICKET_BITS = bkt_pkg::TICKET_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bkt_pkg::bkt_scan_ctl_type      ctl,
   input  logic [$clog2(NUM_CLIENTS)-1:0] beat_idx,
   input  logic [TICKET_BITS-1:0]         beat_data,
   input  logic                           excl_en,
   input  logic [$clog2(NUM_CLIENTS)-1:0] excl_idx,
   output logic [TICKET_BITS-1:0]         max_ticket,
   output logic                           min_valid,
   output logic [TICKET_BITS-1:0]         min_ticket,
   output logic [$clog2(NUM_CLIENTS)-1:0] min_idx
);
   import bkt_pkg::*;

   localparam int IDX_W = $clog2(NUM_CLIENTS);

   logic [TICKET_BITS-1:0] max_ff;
   logic                   minv_ff;
   logic [TICKET_BITS-1:0] min_ff;
   logic [IDX_W-1:0]       minidx_ff;
   logic                   take;

   // strict compare keeps the lower index on a tie
   assign take = ctl.beat && !(excl_en && (beat_idx == excl_idx)) &&
                 (beat_data != '0) && (!minv_ff || (beat_data < min_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         minv_ff <= 1'b0;
      end else if (ctl.clear) begin
         minv_ff <= 1'b0;
      end else if (take) begin
         minv_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         max_ff <= '0;
      end else if (ctl.beat && (beat_data > max_ff)) begin
         max_ff <= beat_data;
      end
      if (take) begin
         min_ff    <= beat_data;
         minidx_ff <= beat_idx;
      end
   end

   assign max_ticket = max_ff;
   assign min_valid  = minv_ff;
   assign min_ticket = min_ff;
   assign min_idx    = minidx_ff;

endmodule

@@ design/bakery_ticket_lock_arbiter.sv @@
// ----------------------------------------------------------------------------
// bakery_ticket_lock_arbiter
// Ticket-ordered lock arbiter: request/release words in, one result word out.
// ----------------------------------------------------------------------------
// For each request or release word, the ticket store is read one entry per
// cycle to find the largest ticket and the smallest nonzero ticket of the
// other clients, then the client's new ticket is written back and the grant
// holder is resolved. The next word is taken as soon as the previous one is
// written back; the result word waits in an output register until it is
// taken, and that register must be free before the following result can be
// loaded.
// Tickets saturate at 2^TICKET_BITS - 1 with the overflow flag set.
// ----------------------------------------------------------------------------
module bakery_ticket_lock_arbiter #(
   parameter int NUM_CLIENTS = bkt_pkg::NUM_CLIENTS_DEF,
   parameter int TICKET_BITS = bkt_pkg::TICKET_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   bkt_req_if.sink          req_ch,
   bkt_rsp_if.source        rsp_ch
);
   import bkt_pkg::*;

   localparam int IDX_W = $clog2(NUM_CLIENTS);
   localparam int XW    = ((IDX_W > CLIENT_W) ? IDX_W : CLIENT_W) + 1;
   localparam int TW    = (TICKET_BITS > TICKET_OUT_W) ? TICKET_BITS : TICKET_OUT_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_LAST   = 4'b0100,
      ST_FINISH = 4'b1000
   } bkt_state_type;

   bkt_state_type state_ff, state_in;

   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic                    beat_ff;
   logic [IDX_W-1:0]        beat_idx_ff;
   logic                    op_ff;
   logic [IDX_W-1:0]        cl_idx_ff;
   logic                    in_range_ff;

   logic                    rsp_valid_ff;
   logic [TICKET_OUT_W-1:0] rsp_ticket_ff;
   logic                    rsp_ovf_ff;
   logic                    rsp_gvalid_ff;
   logic [CLIENT_W-1:0]     rsp_gclient_ff;

   logic                    accept;
   logic                    finish;
   logic [XW-1:0]           req_cl_x;
   logic [XW-1:0]           grant_x;
   logic [TW-1:0]           held_x;

   bkt_scan_ctl_type        scan_ctl;
   logic [TICKET_BITS-1:0]  rd_data;
   logic [TICKET_BITS-1:0]  max_ticket;
   logic                    min_valid;
   logic [TICKET_BITS-1:0]  min_ticket;
   logic [IDX_W-1:0]        min_idx;

   logic                    saturate;
   logic [TICKET_BITS-1:0]  new_ticket;
   logic [TICKET_BITS-1:0]  held;
   logic                    ovf;
   logic                    own_wins;
   logic                    gvalid;
   logic [IDX_W-1:0]        gidx;

   assign req_cl_x = XW'(req_ch.client);
   assign accept   = req_ch.valid && req_ch.ready;
   assign finish   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == IDX_W'(NUM_CLIENTS - 1)) begin
               state_in = ST_LAST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         beat_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         beat_ff  <= (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      beat_idx_ff <= cnt_ff;
      if (accept) begin
         op_ff       <= req_ch.op;
         cl_idx_ff   <= req_cl_x[IDX_W-1:0];
         in_range_ff <= (req_cl_x < XW'(NUM_CLIENTS));
      end
   end

   assign scan_ctl.clear = accept;
   assign scan_ctl.beat  = beat_ff;

   bkt_ticket_ram #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .TICKET_BITS (TICKET_BITS)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (cnt_ff),
      .rd_data (rd_data),
      .wr_en   (finish && in_range_ff),
      .wr_addr (cl_idx_ff),
      .wr_data (new_ticket)
   );

   bkt_scan_acc #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .TICKET_BITS (TICKET_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .beat_idx   (beat_idx_ff),
      .beat_data  (rd_data),
      .excl_en    (in_range_ff),
      .excl_idx   (cl_idx_ff),
      .max_ticket (max_ticket),
      .min_valid  (min_valid),
      .min_ticket (min_ticket),
      .min_idx    (min_idx)
   );

   assign saturate   = (max_ticket == '1);
   assign new_ticket = (op_ff == OP_RELEASE) ? '0 :
                       (saturate ? max_ticket : max_ticket + 1'b1);
   assign held       = in_range_ff ? new_ticket : '0;
   assign ovf        = in_range_ff && (op_ff == OP_REQUEST) && saturate;

   assign own_wins = (held != '0) &&
                     (!min_valid || (held < min_ticket) ||
                      ((held == min_ticket) && (cl_idx_ff < min_idx)));
   assign gvalid   = own_wins || min_valid;
   assign gidx     = own_wins ? cl_idx_ff : (min_valid ? min_idx : '0);
   assign held_x   = TW'(held);
   assign grant_x  = XW'(gidx);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ticket_ff  <= held_x[TICKET_OUT_W-1:0];
         rsp_ovf_ff     <= ovf;
         rsp_gvalid_ff  <= gvalid;
         rsp_gclient_ff <= grant_x[CLIENT_W-1:0];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.ticket       = rsp_ticket_ff;
   assign rsp_ch.overflow     = rsp_ovf_ff;
   assign rsp_ch.grant_valid  = rsp_gvalid_ff;
   assign rsp_ch.grant_client = rsp_gclient_ff;

   a_ovf_has_holder : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> rsp_gvalid_ff)
      else $error("overflow reported without a grant holder");

   a_ticket_has_holder : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ticket_ff != '0)) |-> rsp_gvalid_ff)
      else $error("nonzero ticket reported without a grant holder");

   a_last_after_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST) |-> $past(state_ff == ST_SCAN))
      else $error("final beat without a preceding scan");

   a_accept_starts_scan : assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff == ST_SCAN) && (cnt_ff == '0)))
      else $error("accepted word did not start a scan at entry zero");

endmodule

@@ bench/bkt_grant_checker.sv @@
// ----------------------------------------------------------------------------
// bkt_grant_checker
// Watches the request and result channels of the bakery ticket lock arbiter.
// Keeps its own ticket book, works out the result word for each accepted
// request word, and compares every accepted result word field by field with
// the oldest outstanding prediction. It reports mismatches, counts them, and
// hands the counts to the testbench top.
// ----------------------------------------------------------------------------
module bkt_grant_checker #(
   parameter int NUM_CLIENTS = bkt_pkg::NUM_CLIENTS_DEF,
   parameter int TICKET_BITS = bkt_pkg::TICKET_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   bkt_req_if   req_ch,
   bkt_rsp_if   rsp_ch,
   output int   fail_count,
   output int   pending_words,
   output int   words_checked,
   output int   overflow_hits,
   output int   idle_grants
);
   timeunit 1ns;
   timeprecision 1ps;

   import bkt_pkg::*;

   typedef struct packed {
      logic [TICKET_OUT_W-1:0] ticket;
      logic                    overflow;
      logic                    grant_valid;
      logic [CLIENT_W-1:0]     grant_client;
   } grant_word_type;

   localparam logic [TICKET_BITS-1:0] TICKET_FULL = '1;
   localparam int                     PRINT_CAP   = 40;

   logic [TICKET_BITS-1:0] ticket_book [NUM_CLIENTS];
   grant_word_type         pending_grants [$];

   initial begin
      fail_count    = 0;
      pending_words = 0;
      words_checked = 0;
      overflow_hits = 0;
      idle_grants   = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (fail_count < PRINT_CAP)
         $display("%0t ns: word %0d %s: got 0x%0h, want 0x%0h",
                  $time, words_checked, what, got, want);
      fail_count++;
   endtask

   task automatic advance_ticket_book(input logic op, input logic [CLIENT_W-1:0] who,
                                      output grant_word_type res);
      logic [TICKET_BITS-1:0] top;
      logic [TICKET_BITS-1:0] low;
      logic                   any;
      int                     i;
      res = '0;
      if (int'(who) < NUM_CLIENTS) begin
         if (op == OP_REQUEST) begin
            top = '0;
            for (i = 0; i < NUM_CLIENTS; i++) begin
               if (ticket_book[i] > top) top = ticket_book[i];
            end
            if (top == TICKET_FULL) begin
               ticket_book[who] = TICKET_FULL;
               res.overflow = 1'b1;
            end else begin
               ticket_book[who] = top + 1'b1;
            end
         end else begin
            ticket_book[who] = '0;
         end
         res.ticket = TICKET_OUT_W'(ticket_book[who]);
      end
      any = 1'b0;
      low = '0;
      for (i = 0; i < NUM_CLIENTS; i++) begin
         if (ticket_book[i] != '0 && (!any || ticket_book[i] < low)) begin
            any = 1'b1;
            low = ticket_book[i];
            res.grant_client = CLIENT_W'(i);
         end
      end
      res.grant_valid = any;
   endtask

   always @(posedge clock) begin
      grant_word_type want_w;
      grant_word_type got_w;
      int             i;
      if (reset) begin
         for (i = 0; i < NUM_CLIENTS; i++) ticket_book[i] = '0;
         pending_grants.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            advance_ticket_book(req_ch.op, req_ch.client, want_w);
            pending_grants.push_back(want_w);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_w.ticket       = rsp_ch.ticket;
            got_w.overflow     = rsp_ch.overflow;
            got_w.grant_valid  = rsp_ch.grant_valid;
            got_w.grant_client = rsp_ch.grant_client;
            if (pending_grants.size() == 0) begin
               report_mismatch("result word with nothing outstanding", got_w, 0);
            end else begin
               want_w = pending_grants.pop_front();
               if (got_w.ticket !== want_w.ticket)
                  report_mismatch("ticket", got_w.ticket, want_w.ticket);
               if (got_w.overflow !== want_w.overflow)
                  report_mismatch("overflow", got_w.overflow, want_w.overflow);
               if (got_w.grant_valid !== want_w.grant_valid)
                  report_mismatch("grant_valid", got_w.grant_valid, want_w.grant_valid);
               if (got_w.grant_client !== want_w.grant_client)
                  report_mismatch("grant_client", got_w.grant_client, want_w.grant_client);
               if (want_w.overflow) overflow_hits++;
               if (!want_w.grant_valid) idle_grants++;
            end
            words_checked++;
         end
      end
      pending_words = pending_grants.size();
   end

endmodule

@@ bench/tb_bakery_ticket_lock_arbiter.sv @@
// ----------------------------------------------------------------------------
// tb_bakery_ticket_lock_arbiter
// Drives request and release words into the bakery ticket lock arbiter: a
// directed opening, a climb of requests into ticket saturation, then random
// episodes of varying request density with occasional full drains. Both
// channels idle at random, and the receiver once holds off long enough to
// back the block up. Checking is done by bkt_grant_checker.
// ----------------------------------------------------------------------------
module tb_bakery_ticket_lock_arbiter;
   timeunit 1ns;
   timeprecision 1ps;

   import bkt_pkg::*;

   localparam int WORD_GOAL    = 1150;
   localparam int CLIMB_WORDS  = 280;
   localparam int LATENCY      = NUM_CLIENTS_DEF + 3;
   localparam int HOLD_CYCLES  = 250;
   localparam int HOLD_AT_WORD = 600;
   localparam int DRAIN_LIMIT  = 5000;

   logic clock;
   logic reset;
   logic req_lazy;
   logic rsp_lazy;
   logic hold_rsp;
   int   words_sent;
   int   fail_count;
   int   pending_words;
   int   words_checked;
   int   overflow_hits;
   int   idle_grants;

   bkt_req_if req_ch ();
   bkt_rsp_if rsp_ch ();

   bakery_ticket_lock_arbiter DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bkt_grant_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .words_checked (words_checked),
      .overflow_hits (overflow_hits),
      .idle_grants   (idle_grants)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #5_000_000;
      $display("timeout after %0d words sent, %0d checked", words_sent, words_checked);
      $display("bakery_ticket_lock_arbiter verification failed");
      $finish;
   end

   task automatic send_word(input logic op, input logic [CLIENT_W-1:0] who);
      int gap;
      gap = req_lazy ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.op     <= op;
      req_ch.client <= who;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   task automatic run_episode();
      int len;
      int pct;
      len = $urandom_range(20, 80);
      case ($urandom_range(0, 3))
         0: pct = 25;
         1: pct = 50;
         2: pct = 75;
         default: pct = 90;
      endcase
      req_lazy = $urandom_range(0, 3) != 0;
      rsp_lazy = $urandom_range(0, 3) != 0;
      repeat (len) begin
         send_word(($urandom_range(0, 99) < pct) ? OP_REQUEST : OP_RELEASE,
                   CLIENT_W'($urandom_range(0, 15)));
      end
   endtask

   task automatic drain_all();
      int order [16];
      int i;
      int j;
      int t;
      for (i = 0; i < 16; i++) order[i] = i;
      for (i = 15; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (i = 0; i < 16; i++) send_word(OP_RELEASE, CLIENT_W'(order[i]));
   endtask

   // receiver: random stall before each word, long hold when asked
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = rsp_lazy ? $urandom_range(0, 6) : 0;
         while (gap > 0 || hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
            if (gap > 0) gap--;
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      hold_rsp = 1'b0;
      wait (words_sent >= HOLD_AT_WORD);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      int drain;
      reset         = 1'b1;
      req_lazy      = 1'b0;
      rsp_lazy      = 1'b0;
      words_sent    = 0;
      req_ch.valid  = 1'b0;
      req_ch.op     = OP_REQUEST;
      req_ch.client = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening: empty release, extremes, re-request, ordered release
      send_word(OP_RELEASE, 4'd0);
      send_word(OP_REQUEST, 4'd15);
      send_word(OP_REQUEST, 4'd0);
      send_word(OP_REQUEST, 4'd15);
      send_word(OP_REQUEST, 4'd7);
      send_word(OP_RELEASE, 4'd0);
      send_word(OP_RELEASE, 4'd15);
      send_word(OP_RELEASE, 4'd7);
      send_word(OP_RELEASE, 4'd7);
      send_word(OP_REQUEST, 4'd0);
      send_word(OP_REQUEST, 4'd0);
      send_word(OP_RELEASE, 4'd0);

      // climb into saturation, then spread ties
      req_lazy = 1'b1;
      rsp_lazy = 1'b1;
      repeat (CLIMB_WORDS) send_word(OP_REQUEST, CLIENT_W'($urandom_range(0, 15)));
      repeat (12) send_word(OP_RELEASE, CLIENT_W'($urandom_range(0, 15)));
      repeat (12) send_word(OP_REQUEST, CLIENT_W'($urandom_range(0, 15)));
      drain_all();

      while (words_sent < WORD_GOAL) begin
         run_episode();
         if ($urandom_range(0, 3) == 0) drain_all();
      end
      req_ch.valid <= 1'b0;

      drain = 0;
      while (pending_words != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (2 * LATENCY) @(posedge clock);

      $display("sent %0d request/release words, checked %0d result words",
               words_sent, words_checked);
      $display("saturated requests: %0d, results with no holder: %0d, long hold: %0d cycles",
               overflow_hits, idle_grants, HOLD_CYCLES);
      if (pending_words != 0)
         $display("%0d result words never arrived", pending_words);
      if (fail_count == 0 && pending_words == 0) begin
         $display("bakery_ticket_lock_arbiter verification clean");
      end else begin
         $display("bakery_ticket_lock_arbiter verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/bkt_pkg.sv
design/bkt_if.sv
design/bkt_ticket_ram.sv
design/bkt_scan_acc.sv
design/bakery_ticket_lock_arbiter.sv
bench/bkt_grant_checker.sv
bench/tb_bakery_ticket_lock_arbiter.sv
